// ----- sv/dpc_pkg.sv -----
// Shared constants and command/status types for the staircase counter.
// Used by dpc_ctrl, dpc_datapath and distinct_partition_counter_top.
package dpc_pkg;

  localparam int MAX_CUBES = 512;
  localparam int N_W       = 10;
  localparam int CNT_W     = 48;
  localparam int DEPTH     = MAX_CUBES + 1;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam logic [CNT_W-1:0] CNT_CAP = {CNT_W{1'b1}};

  // Controller to datapath.
  typedef struct packed {
    logic load;       // latch cube count, reset counters
    logic clr_write;  // write one table entry of the clearing pass
    logic upd_issue;  // read s and s-k, step s down
    logic k_next;     // close a pass: next part, s back to n
    logic fin_read;   // read the entry for n
    logic res_load;   // capture the result into the output register
  } dpc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic too_big;
    logic clr_done;
    logic n_zero;
    logic last_issue;
    logic last_pass;
  } dpc_status_t;

endpackage

// ----- sv/dpc_datapath.sv -----
// Datapath of the staircase counter: table memory, saturating adder,
// part and sum counters, result register. Depends on dpc_pkg.
module dpc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  dpc_pkg::dpc_cmd_t           cmd,
  input  logic [dpc_pkg::N_W-1:0]     cube_count,
  output dpc_pkg::dpc_status_t        status,
  output logic [dpc_pkg::CNT_W-1:0]   staircase_total,
  output logic                        too_large
);

  logic [dpc_pkg::CNT_W-1:0]  table_mem [dpc_pkg::DEPTH];

  logic [dpc_pkg::N_W-1:0]    n_reg;
  logic [dpc_pkg::ADDR_W-1:0] n_addr;
  logic [dpc_pkg::ADDR_W-1:0] k;
  logic [dpc_pkg::ADDR_W-1:0] s;
  logic [dpc_pkg::ADDR_W-1:0] clr_addr;
  logic [dpc_pkg::ADDR_W-1:0] rd_addr_a;
  logic [dpc_pkg::ADDR_W-1:0] rd_addr_b;
  logic [dpc_pkg::CNT_W-1:0]  rd_a;
  logic [dpc_pkg::CNT_W-1:0]  rd_b;
  logic                       wr_pend;
  logic [dpc_pkg::ADDR_W-1:0] wr_addr;
  logic [dpc_pkg::CNT_W:0]    sum_full;
  logic [dpc_pkg::CNT_W-1:0]  sum_sat;
  logic                       wr_en;
  logic [dpc_pkg::ADDR_W-1:0] wr_sel;
  logic [dpc_pkg::CNT_W-1:0]  wr_data;
  logic [dpc_pkg::CNT_W-1:0]  q_adj;

  assign n_addr = n_reg[dpc_pkg::ADDR_W-1:0];

  assign status.too_big    = (n_reg > dpc_pkg::N_W'(dpc_pkg::MAX_CUBES));
  assign status.clr_done   = (clr_addr == n_addr);
  assign status.n_zero     = (n_reg == '0);
  assign status.last_issue = (s == k);
  assign status.last_pass  = (k == n_addr);

  // Saturate each table addition at the counter cap.
  assign sum_full = {1'b0, rd_a} + {1'b0, rd_b};
  assign sum_sat  = sum_full[dpc_pkg::CNT_W] ? dpc_pkg::CNT_CAP
                                             : sum_full[dpc_pkg::CNT_W-1:0];

  assign rd_addr_a = cmd.fin_read ? n_addr : s;
  assign rd_addr_b = s - k;

  always_comb begin
    wr_en   = 1'b0;
    wr_sel  = wr_addr;
    wr_data = sum_sat;
    if (cmd.clr_write) begin
      wr_en   = 1'b1;
      wr_sel  = clr_addr;
      wr_data = (clr_addr == '0) ? dpc_pkg::CNT_W'(1) : '0;
    end else if (wr_pend) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_sel] <= wr_data;
    end
    if (cmd.upd_issue || cmd.fin_read) begin
      rd_a <= table_mem[rd_addr_a];
    end
    // s-k is only a live address while a pass is issuing
    if (cmd.upd_issue) begin
      rd_b <= table_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.upd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_issue) begin
      wr_addr <= s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_reg    <= cube_count;
      s        <= cube_count[dpc_pkg::ADDR_W-1:0];
      k        <= dpc_pkg::ADDR_W'(1);
      clr_addr <= '0;
    end else begin
      if (cmd.clr_write) begin
        clr_addr <= clr_addr + dpc_pkg::ADDR_W'(1);
      end
      if (cmd.upd_issue) begin
        s <= s - dpc_pkg::ADDR_W'(1);
      end
      if (cmd.k_next) begin
        k <= k + dpc_pkg::ADDR_W'(1);
        s <= n_addr;
      end
    end
  end

  // Drop the single-part partition unless the count has saturated.
  assign q_adj = (rd_a == dpc_pkg::CNT_CAP) ? dpc_pkg::CNT_CAP
                                            : rd_a - dpc_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      too_large       <= status.too_big;
      staircase_total <= status.too_big ? '0 : q_adj;
    end
  end

  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_issue |-> (k != '0) && (k <= n_addr) && (s >= k))
    else $error("table update issued outside the current pass");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (wr_addr >= k) && (wr_addr <= n_addr))
    else $error("table write-back outside the live sums");

  a_clear_range: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_write |-> (clr_addr <= n_addr) && !wr_pend)
    else $error("clearing write out of range or colliding with write-back");

endmodule

// ----- sv/dpc_ctrl.sv -----
// Sequencer of the staircase counter: clearing pass, table passes,
// final read and output handshake. Depends on dpc_pkg.
module dpc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  dpc_pkg::dpc_status_t  status,
  output dpc_pkg::dpc_cmd_t     cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_PASS  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_READN = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (status.too_big) begin
          state_next = S_DONE;
        end else begin
          cmd.clr_write = 1'b1;
          if (status.clr_done) begin
            state_next = status.n_zero ? S_READN : S_PASS;
          end
        end
      end
      S_PASS: begin
        cmd.upd_issue = 1'b1;
        if (status.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // pause here so the last write-back lands before the next reads
        cmd.k_next = 1'b1;
        state_next = status.last_pass ? S_READN : S_PASS;
      end
      S_READN: begin
        cmd.fin_read = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.res_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && out_valid && !out_ready |=> (state == S_DONE))
    else $error("finished request left while output was stalled");

endmodule

// ----- sv/distinct_partition_counter_top.sv -----
// Staircase counter: for a cube count n returns the number of partitions of n
// into two or more distinct parts, with a flag for counts above MAX_CUBES.
// Each request clears table entries 0 to n, then runs one table update per cycle
// through the single saturating adder and table memory, closes each part's pass
// in a drain state, and ends with a final read of entry n. Counts above MAX_CUBES
// skip the table and go straight to the result. One request is in work at a time;
// the next one is taken while a finished result still waits in the output register.
module distinct_partition_counter_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dpc_pkg::N_W-1:0]    cube_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dpc_pkg::CNT_W-1:0]  staircase_total,
  output logic                       too_large
);

  dpc_pkg::dpc_cmd_t    cmd;
  dpc_pkg::dpc_status_t status;

  dpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dpc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cube_count      (cube_count),
    .status          (status),
    .staircase_total (staircase_total),
    .too_large       (too_large)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for distinct_partition_counter_top: predicts each staircase
// total with its own saturating table fill and compares it with every result.
// Depends on dpc_pkg and the top level only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [dpc_pkg::CNT_W-1:0] total;
    logic                      over;
  } staircase_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [dpc_pkg::N_W-1:0]   cube_count = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [dpc_pkg::CNT_W-1:0] staircase_total;
  logic                      too_large;

  staircase_t pending_totals[$];
  int         mismatches = 0;
  int         hold_left = 0;
  bit         no_gaps = 1'b0;

  distinct_partition_counter_top u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cube_count      (cube_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .staircase_total (staircase_total),
    .too_large       (too_large)
  );

  always #5 clk = ~clk;

  // Distinct-part partition count by table fill, every addition saturating.
  function automatic staircase_t count_staircases(input logic [dpc_pkg::N_W-1:0] n);
    logic [dpc_pkg::CNT_W-1:0] parts [0:dpc_pkg::MAX_CUBES];
    logic [dpc_pkg::CNT_W:0]   sum;
    staircase_t                res;
    int                        lim;
    res.total = '0;
    res.over  = 1'b0;
    if (n > dpc_pkg::N_W'(dpc_pkg::MAX_CUBES)) begin
      res.over = 1'b1;
      return res;
    end
    foreach (parts[i]) parts[i] = '0;
    parts[0] = dpc_pkg::CNT_W'(1);
    lim = int'(n);
    for (int k = 1; k <= lim; k++) begin
      for (int s = lim; s >= k; s--) begin
        sum = {1'b0, parts[s]} + {1'b0, parts[s-k]};
        parts[s] = sum[dpc_pkg::CNT_W] ? dpc_pkg::CNT_CAP : sum[dpc_pkg::CNT_W-1:0];
      end
    end
    // a saturated count stays at the cap, otherwise drop the one-part partition
    res.total = (parts[lim] == dpc_pkg::CNT_CAP) ? dpc_pkg::CNT_CAP
                                                  : parts[lim] - dpc_pkg::CNT_W'(1);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(30, 200);
  endfunction

  task automatic send_count(input logic [dpc_pkg::N_W-1:0] n);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cube_count <= n;
    do @(posedge clk); while (!in_ready);
    pending_totals.push_back(count_staircases(n));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_totals.size() > 0) @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int phase_left;
    int gap;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (phase_left > 0) begin
        phase_left--;
      end else if (out_ready) begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready  <= 1'b0;
          phase_left = gap - 1;
        end
      end else begin
        out_ready  <= 1'b1;
        phase_left = $urandom_range(0, 15);
      end
    end
  end

  task automatic report_mismatch(input string what, input staircase_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected total=%0d too_large=%0b, got total=%0d too_large=%0b",
               $realtime, what, want.total, want.over, staircase_total, too_large);
  endtask

  always @(posedge clk) begin
    staircase_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_totals.size() == 0) begin
        want.total = '0;
        want.over  = 1'b0;
        report_mismatch("unexpected result", want);
      end else begin
        want = pending_totals.pop_front();
        if (staircase_total !== want.total || too_large !== want.over)
          report_mismatch("wrong result", want);
      end
    end
  end

  task automatic test_small_counts();
    for (int n = 0; n <= 7; n++) send_count(n[dpc_pkg::N_W-1:0]);
    send_count(10'd100);
  endtask

  task automatic test_over_bound();
    send_count(10'(dpc_pkg::MAX_CUBES + 1));
    send_count(10'd768);
    send_count(10'd1023);
    send_count(10'd600);
  endtask

  // Large counts: unsaturated, past the saturation point, and the bound itself.
  task automatic test_large_counts();
    send_count(10'd300);
    send_count(10'd480);
    send_count(10'(dpc_pkg::MAX_CUBES));
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    no_gaps   = 1'b1;
    for (int i = 0; i < 8; i++) send_count(10'($urandom_range(0, 12)));
    no_gaps   = 1'b0;
    drain();
  endtask

  task automatic test_random_counts();
    int r;
    for (int i = 0; i < 80; i++) begin
      // hold both sides busy for a stretch
      no_gaps = (i >= 40 && i < 60);
      r = $urandom_range(0, 99);
      if (r < 75)      send_count(10'($urandom_range(0, 40)));
      else if (r < 88) send_count(10'($urandom_range(41, 160)));
      else if (r < 98) send_count(10'($urandom_range(dpc_pkg::MAX_CUBES + 1, 1023)));
      else             send_count(10'($urandom_range(161, 250)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_counts();
    test_over_bound();
    test_large_counts();
    drain();
    test_backpressure();
    test_random_counts();
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_totals.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
